// ===== rtl/core/nvh_pkg.sv =====
package nvh_pkg;

    typedef logic [63:0] t_word;

    localparam int unsigned FMIX_SHIFT = 33;
    localparam t_word FMIX_MUL_A = 64'hff51_afd7_ed55_8ccd;
    localparam t_word FMIX_MUL_B = 64'hc4ce_b9fe_1a85_ec53;

    // keys for the infinities; negative one is -271828 in two's complement
    localparam t_word KEY_POS_INF = 64'd314159;
    localparam t_word KEY_NEG_INF = 64'hffff_ffff_fffb_da2c;

    localparam int unsigned MANT_BITS = 52;
    localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    // biased exponent at which the mantissa LSB has weight one
    localparam logic [10:0] EXP_UNIT = 11'd1075;

    function automatic t_word xor_shift(input t_word h);
        xor_shift = h ^ (h >> FMIX_SHIFT);
    endfunction

endpackage

// ===== rtl/core/nvh_key_decode.sv =====
module nvh_key_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_action,
    input  nvh_pkg::t_word i_value_bits,
    output logic          o_valid,
    input  logic          i_ready,
    output nvh_pkg::t_word o_key
);
    import nvh_pkg::*;

    logic        neg;
    logic [10:0] bexp;
    logic [51:0] mant;
    logic [52:0] sig;
    logic [10:0] sh_l;
    logic [10:0] sh_r;
    logic [52:0] fmask;
    t_word       mag;
    t_word       dkey;
    t_word       n_key;
    logic        r_valid;
    t_word       r_key;

    always_comb begin
        neg   = i_value_bits[63];
        bexp  = i_value_bits[62:52];
        mant  = i_value_bits[51:0];
        sig   = {1'b1, mant};
        sh_l  = bexp - EXP_UNIT;
        sh_r  = EXP_UNIT - bexp;
        fmask = ~({53{1'b1}} << sh_r[5:0]);
        if (bexp >= EXP_UNIT) begin
            // integral, shift up; beyond 63 only zeros remain
            mag = (sh_l >= 11'd64) ? '0 : ({11'd0, sig} << sh_l[5:0]);
        end else begin
            mag = {11'd0, sig >> sh_r[5:0]};
        end
        priority if (bexp == EXP_ALL_ONES) begin
            if (mant != '0) dkey = '0;
            else            dkey = neg ? KEY_NEG_INF : KEY_POS_INF;
        end else if (bexp == '0) begin
            dkey = (mant == '0) ? '0 : i_value_bits;
        end else if (bexp < EXP_BIAS) begin
            dkey = i_value_bits;
        end else if (bexp < EXP_UNIT && (sig & fmask) != '0) begin
            dkey = i_value_bits;
        end else begin
            dkey = neg ? (t_word'(0) - mag) : mag;
        end
        n_key = i_action ? dkey : i_value_bits;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_key <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

// ===== rtl/core/nvh_mul_stage.sv =====
module nvh_mul_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  nvh_pkg::t_word i_h,
    input  nvh_pkg::t_word i_mult,
    output logic          o_valid,
    input  logic          i_ready,
    output nvh_pkg::t_word o_prod
);
    import nvh_pkg::*;

    // low 64 bits of x*m from three 32x32 partial products
    t_word       x;
    t_word       n_pp_ll;
    logic [31:0] n_pp_hl;
    logic [31:0] n_pp_lh;
    logic        pp_ready;
    logic        sum_ready;
    logic        r_pp_valid;
    t_word       r_pp_ll;
    logic [31:0] r_pp_hl;
    logic [31:0] r_pp_lh;
    logic        r_sum_valid;
    t_word       r_prod;
    logic [31:0] cross_sum;

    always_comb begin
        x         = xor_shift(i_h);
        n_pp_ll   = {32'd0, x[31:0]} * {32'd0, i_mult[31:0]};
        n_pp_hl   = x[63:32] * i_mult[31:0];
        n_pp_lh   = x[31:0] * i_mult[63:32];
        cross_sum = r_pp_hl + r_pp_lh;
    end

    assign sum_ready = !r_sum_valid || i_ready;
    assign pp_ready  = !r_pp_valid || sum_ready;
    assign o_ready   = pp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
        end else begin
            if (pp_ready) r_pp_valid <= i_valid;
            if (sum_ready) r_sum_valid <= r_pp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pp_ready && i_valid) begin
            r_pp_ll <= n_pp_ll;
            r_pp_hl <= n_pp_hl;
            r_pp_lh <= n_pp_lh;
        end
        if (sum_ready && r_pp_valid) begin
            r_prod <= r_pp_ll + {cross_sum, 32'd0};
        end
    end

    assign o_valid = r_sum_valid;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/core/numeric_value_hash_core.sv =====
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------
// request | in        | i_valid / o_stall   | i_action, i_value_bits
// result  | out       | o_valid / i_stall   | o_digest
//
// Five register stages: key decode, then two multiply rounds of two stages
// each (32x32 partial products, then the 64-bit sum).
// One request per cycle sustained while i_stall is low; the partial-product multipliers set
// the stage depth.
// Synchronous active-low reset clears the valid bits only.
// Each stage holds while the one after it is full and stalled, so bubbles
// collapse and new requests enter while a result waits on i_stall.
module numeric_value_hash_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_action,
    input  nvh_pkg::t_word i_value_bits,
    output logic          o_valid,
    input  logic          i_stall,
    output nvh_pkg::t_word o_digest
);
    import nvh_pkg::*;

    // key decode -> round A
    logic  dec_ready;
    logic  dec_valid;
    t_word dec_key;
    // round A -> round B
    logic  mula_ready;
    logic  mula_valid;
    t_word mula_prod;
    // round B -> output
    logic  mulb_ready;
    t_word mulb_prod;

    // double to integer key (integer requests pass straight through)
    nvh_key_decode u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (dec_ready),
        .i_action     (i_action),
        .i_value_bits (i_value_bits),
        .o_valid      (dec_valid),
        .i_ready      (mula_ready),
        .o_key        (dec_key)
    );

    // xor-shift, multiply by first constant
    nvh_mul_stage u_mula (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (mula_ready),
        .i_h     (dec_key),
        .i_mult  (FMIX_MUL_A),
        .o_valid (mula_valid),
        .i_ready (mulb_ready),
        .o_prod  (mula_prod)
    );

    // xor-shift, multiply by second constant; last register feeds the port
    nvh_mul_stage u_mulb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mula_valid),
        .o_ready (mulb_ready),
        .i_h     (mula_prod),
        .i_mult  (FMIX_MUL_B),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_prod  (mulb_prod)
    );

    assign o_stall  = !dec_ready;
    // final xor-shift is a single xor level after the output register
    assign o_digest = xor_shift(mulb_prod);

`ifndef SYNTH
    // input can only back up once every stage holds a request
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && dec_valid && mula_valid))
        else $error("input stalled with a free stage in the pipeline");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule
